// ===== design/mdsr_pkg.sv =====
// Package for the mixed data set reassembler.
// Holds sizes, packet and event codes and the per-stream slot record.
// No dependencies; the top level refers to it by scoped names.
package mdsr_pkg;

  // Number of stream slots and payload bytes carried by one payload packet.
  localparam int unsigned NumStreams   = 16;
  localparam int unsigned PayloadBytes = 14;
  localparam int unsigned CntW         = $clog2(PayloadBytes + 1);
  localparam int unsigned ResW         = $clog2(PayloadBytes + 2);

  // Fixed sizes of the header layout.
  localparam logic [15:0] HeaderBytes = 16'd16;
  localparam logic [16:0] PacketRound = 17'd15;

  // Packet kinds on the input channel.
  localparam logic [1:0] PkHeader  = 2'd1;
  localparam logic [1:0] PkPayload = 2'd2;

  // Event kinds on the output channel.
  localparam logic [1:0] EvData    = 2'd0;
  localparam logic [1:0] EvDone    = 2'd1;
  localparam logic [1:0] EvDiscard = 2'd2;

  // State kept for one stream.
  typedef struct packed {
    logic        active;
    logic [15:0] chunk_total;
    logic [15:0] chunks_done;
    logic [15:0] bytes_left;
    logic [31:0] set_size;
    logic [63:0] header_ids;
  } slot_t;

endpackage

// ===== design/mixed_data_set_reassembler.sv =====
// Top level of the mixed data set reassembler.
// Depends on mdsr_pkg for codes, sizes and the slot record.
// Holds the input register, the per-stream slots and the result sequencer.
//
//   channel | direction | handshake               | content
//   --------+-----------+-------------------------+-------------------------------
//   in      | to block  | in_valid_i / in_stall_o   | one header or payload packet
//   out     | from block| out_valid_o / out_stall_i | one data, done or discard event
//   cfg     | to block  | cfg_valid_i / cfg_ready_o | max_set_bytes write data
//
// An item waits in the input register, is decoded combinationally against its slot
// as the sequencer takes it and then leaves as 0 to 15 result beats, one beat per
// cycle unless the output stalls. The result sequencer sets the rate: it takes the
// next item only when idle or as the last beat of the current item is accepted.
// Reset clears all slots and the size limit; a stalled output holds the sequencer,
// and the input stalls once the input register waits on a busy sequencer.
module mixed_data_set_reassembler (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  packet_kind_i,
  input  logic [3:0]  stream_id_i,
  input  logic [15:0] chunk_number_i,
  input  logic [15:0] chunk_count_i,
  input  logic [15:0] chunk_valid_bytes_i,
  input  logic [15:0] manufacturer_code_i,
  input  logic [15:0] device_code_i,
  input  logic [15:0] sub_code_one_i,
  input  logic [15:0] sub_code_two_i,
  input  logic [63:0] payload_low_i,
  input  logic [47:0] payload_high_i,
  // Output channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_kind_o,
  output logic [3:0]  event_stream_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] set_manufacturer_o,
  output logic [15:0] set_device_o,
  output logic [15:0] set_sub_one_o,
  output logic [15:0] set_sub_two_o,
  output logic        last_of_run_o
);

  // Size limit register.
  logic [31:0] max_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
    end else if (cfg_valid_i) begin
      max_q <= cfg_data_i;
    end
  end

  // Input register.
  logic         item_valid_q;
  logic [1:0]   kind_q;
  logic [3:0]   stream_q;
  logic [15:0]  chunk_q;
  logic [15:0]  total_q;
  logic [15:0]  vbytes_q;
  logic [63:0]  ids_q;
  logic [111:0] payload_q;

  // Result sequencer registers.
  logic                            bnd_valid_q, bnd_valid_d;
  logic [3:0]                      bnd_stream_q, bnd_stream_d;
  logic [mdsr_pkg::CntW-1:0]       bnd_nbytes_q, bnd_nbytes_d;
  logic                            bnd_tail_q, bnd_tail_d;
  logic [1:0]                      bnd_tail_kind_q, bnd_tail_kind_d;
  logic [63:0]                     bnd_ids_q, bnd_ids_d;
  logic [111:0]                    bnd_bytes_q, bnd_bytes_d;
  logic [mdsr_pkg::CntW-1:0]       idx_q, idx_d;

  logic in_accept, out_accept, out_last, bnd_free, take_item;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_o && !out_stall_i;
  assign bnd_free   = !bnd_valid_q || (out_accept && out_last);
  assign take_item  = item_valid_q && bnd_free;
  assign in_stall_o = item_valid_q && !bnd_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_accept) begin
      item_valid_q <= 1'b1;
    end else if (take_item) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q    <= packet_kind_i;
      stream_q  <= stream_id_i;
      chunk_q   <= chunk_number_i;
      total_q   <= chunk_count_i;
      vbytes_q  <= chunk_valid_bytes_i;
      ids_q     <= {sub_code_two_i, sub_code_one_i, device_code_i, manufacturer_code_i};
      payload_q <= {payload_high_i, payload_low_i};
    end
  end

  // Stream slots, read and written at the stream of the item in the register.
  mdsr_pkg::slot_t slot_q [mdsr_pkg::NumStreams];
  mdsr_pkg::slot_t cur, nxt;
  logic            slot_we;
  logic            in_range;

  assign in_range = ({1'b0, stream_q} < 5'(mdsr_pkg::NumStreams));
  assign cur      = in_range ? slot_q[stream_q] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(mdsr_pkg::NumStreams); i++) begin
        slot_q[i] <= '0;
      end
    end else if (slot_we) begin
      slot_q[stream_q] <= nxt;
    end
  end

  // Decode of one item against its slot.
  logic                      is_start;
  logic [15:0]               body;
  logic [12:0]               pkts;
  logic [16:0]               status_bytes;
  logic [15:0]               hdr_left;
  logic [32:0]               hdr_need;
  logic [15:0]               done_base;
  logic [31:0]               size_base;
  logic [63:0]               ids_base;
  logic [15:0]               fin_done;
  logic [15:0]               fin_left;
  logic [15:0]               fin_total;
  logic                      do_finish;
  logic [mdsr_pkg::CntW-1:0] cnt;
  logic [32:0]               size_sum;

  always_comb begin
    is_start     = (chunk_q == 16'd1);
    body         = vbytes_q - mdsr_pkg::HeaderBytes;
    pkts         = 13'(({1'b0, body} + mdsr_pkg::PacketRound) >> 4);
    status_bytes = {3'b000, pkts, 1'b0};
    hdr_left     = body - status_bytes[15:0];
    done_base    = is_start ? 16'd0 : cur.chunks_done;
    size_base    = is_start ? 32'd0 : cur.set_size;
    ids_base     = is_start ? ids_q : cur.header_ids;
    hdr_need     = {1'b0, size_base} + {17'd0, hdr_left};
    if ({12'd0, cur.bytes_left} < mdsr_pkg::PayloadBytes) begin
      cnt = cur.bytes_left[mdsr_pkg::CntW-1:0];
    end else begin
      cnt = mdsr_pkg::CntW'(mdsr_pkg::PayloadBytes);
    end
    size_sum = {1'b0, cur.set_size} + {{(33 - mdsr_pkg::CntW){1'b0}}, cnt};

    slot_we         = 1'b0;
    nxt             = cur;
    do_finish       = 1'b0;
    fin_done        = cur.chunks_done;
    fin_left        = cur.bytes_left;
    fin_total       = cur.chunk_total;
    bnd_nbytes_d    = '0;
    bnd_tail_d      = 1'b0;
    bnd_tail_kind_d = mdsr_pkg::EvDiscard;
    bnd_ids_d       = '0;

    if (take_item && in_range) begin
      if (kind_q == mdsr_pkg::PkHeader) begin
        slot_we = 1'b1;
        if (chunk_q == 16'd0) begin
          // Abort request.
          nxt        = '0;
          bnd_tail_d = 1'b1;
        end else if (!is_start && (!cur.active ||
                     {1'b0, chunk_q} != {1'b0, cur.chunks_done} + 17'd1)) begin
          // Chunk out of order or no open set.
          nxt        = '0;
          bnd_tail_d = 1'b1;
        end else if ((total_q != 16'd0 && chunk_q > total_q) ||
                     vbytes_q < mdsr_pkg::HeaderBytes ||
                     {1'b0, body} < status_bytes ||
                     (max_q != 32'd0 && hdr_need > {1'b0, max_q})) begin
          // Chunk beyond the total, bad byte count or set too large.
          nxt        = '0;
          bnd_tail_d = 1'b1;
        end else begin
          nxt.active      = 1'b1;
          nxt.chunk_total = total_q;
          nxt.chunks_done = done_base;
          nxt.bytes_left  = hdr_left;
          nxt.set_size    = size_base;
          nxt.header_ids  = ids_base;
          do_finish       = (hdr_left == 16'd0);
          fin_done        = done_base;
          fin_left        = hdr_left;
          fin_total       = total_q;
        end
      end else if (kind_q == mdsr_pkg::PkPayload && cur.active &&
                   cur.bytes_left != 16'd0) begin
        // Payload bytes of the current chunk.
        slot_we       = 1'b1;
        bnd_nbytes_d  = cnt;
        fin_left      = cur.bytes_left - {{(16 - mdsr_pkg::CntW){1'b0}}, cnt};
        nxt.bytes_left = fin_left;
        nxt.set_size  = size_sum[32] ? 32'hFFFF_FFFF : size_sum[31:0];
        do_finish     = (fin_left == 16'd0);
      end

      // Chunk completion, possibly closing the set.
      if (do_finish) begin
        if (fin_done != 16'hFFFF) begin
          fin_done = fin_done + 16'd1;
        end
        nxt.chunks_done = fin_done;
        if (fin_total == fin_done) begin
          bnd_tail_d      = 1'b1;
          bnd_tail_kind_d = mdsr_pkg::EvDone;
          bnd_ids_d       = nxt.header_ids;
          nxt             = '0;
        end
      end
    end
  end

  // Result sequencer: data bytes first, then the optional tail event.
  logic [mdsr_pkg::ResW-1:0] res_total;
  logic                      in_bytes;

  assign res_total = mdsr_pkg::ResW'(bnd_nbytes_q) + mdsr_pkg::ResW'(bnd_tail_q);
  assign out_last  = (mdsr_pkg::ResW'(idx_q) + mdsr_pkg::ResW'(1)) == res_total;
  assign in_bytes  = idx_q < bnd_nbytes_q;

  always_comb begin
    bnd_valid_d  = bnd_valid_q;
    bnd_stream_d = bnd_stream_q;
    bnd_bytes_d  = bnd_bytes_q;
    idx_d        = idx_q;
    if (bnd_free) begin
      bnd_valid_d  = bnd_tail_d || (bnd_nbytes_d != '0);
      bnd_stream_d = stream_q;
      bnd_bytes_d  = payload_q;
      idx_d        = '0;
    end else if (out_accept) begin
      idx_d = idx_q + {{(mdsr_pkg::CntW - 1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bnd_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      bnd_valid_q <= bnd_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bnd_stream_q <= bnd_stream_d;
    bnd_bytes_q  <= bnd_bytes_d;
    if (bnd_free) begin
      bnd_nbytes_q    <= bnd_nbytes_d;
      bnd_tail_q      <= bnd_tail_d;
      bnd_tail_kind_q <= bnd_tail_kind_d;
      bnd_ids_q       <= bnd_ids_d;
    end
  end

  // Output beat fields.
  assign out_valid_o    = bnd_valid_q;
  assign event_kind_o   = in_bytes ? mdsr_pkg::EvData : bnd_tail_kind_q;
  assign event_stream_o = bnd_stream_q;
  assign data_byte_o    = in_bytes ? bnd_bytes_q[{idx_q, 3'b000} +: 8] : 8'd0;
  assign set_manufacturer_o = in_bytes ? 16'd0 : bnd_ids_q[15:0];
  assign set_device_o       = in_bytes ? 16'd0 : bnd_ids_q[31:16];
  assign set_sub_one_o      = in_bytes ? 16'd0 : bnd_ids_q[47:32];
  assign set_sub_two_o      = in_bytes ? 16'd0 : bnd_ids_q[63:48];
  assign last_of_run_o      = out_last;

endmodule
